/* rtl/gyro_yaw_fusion_estimator_defines.svh */
// -----------------------------------------------------------------------------
// Gyro yaw fusion estimator assertion macros
// Shared property wrappers, clocked on clock and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef GYRO_YAW_FUSION_ESTIMATOR_DEFINES_SVH
`define GYRO_YAW_FUSION_ESTIMATOR_DEFINES_SVH

// Same-cycle implication.
`define GYF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GYF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/gyf_pkg.sv */
// -----------------------------------------------------------------------------
// gyf_pkg
// Types, codes and constants shared by the gyro yaw fusion estimator.
// -----------------------------------------------------------------------------
package gyf_pkg;

   // Operation codes
   localparam logic [1:0] OP_SAMPLE    = 2'd0;
   localparam logic [1:0] OP_LOAD_CAL  = 2'd1;
   localparam logic [1:0] OP_CLEAR_INT = 2'd2;
   localparam logic [1:0] OP_NOP       = 2'd3;

   // Configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STILL_NEED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_COEF   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUST_ANGLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ERR     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_MOVING = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_STATIC = 3'd7;

   // Serial arithmetic unit widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = 60;
   localparam int DIV_N_W = 42;
   localparam int DIV_D_W = 16;

   localparam logic [7:0]         DT_CAP_MS   = 8'd200;
   localparam logic [7:0]         COUNT_MAX   = 8'd255;
   localparam logic [DIV_D_W-1:0] DT_DIVISOR  = 16'd90;
   localparam logic [DIV_N_W-1:0] DT_ROUND_UP = 42'd89;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] yaw_raw;
      logic signed [15:0] rate_raw;
      logic [31:0]        tick_ms;
      logic signed [15:0] yaw_offset_value;
      logic signed [23:0] bias_value;
   } gyf_req_type;

   typedef struct packed {
      logic signed [15:0] yaw_out;
      logic signed [15:0] yaw_fused;
      logic signed [31:0] yaw_integral;
      logic signed [15:0] yaw_diff;
      logic signed [23:0] bias_out;
      logic               is_still;
      logic               is_calibrated;
   } gyf_rsp_type;

   typedef struct packed {
      logic                      start;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } gyf_mul_req_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } gyf_div_req_type;

   // Clamp to the 24-bit signed bias range.
   function automatic logic signed [23:0] sat_bias(input logic signed [MUL_P_W-1:0] v);
      logic signed [MUL_P_W-1:0] hi;
      logic signed [MUL_P_W-1:0] lo;
      hi = 60'sd8388607;
      lo = -60'sd8388608;
      if (v > hi) begin
         return 24'sh7FFFFF;
      end else if (v < lo) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

endpackage

/* rtl/gyf_smul.sv */
// -----------------------------------------------------------------------------
// gyf_smul
// Signed shift-add multiplier, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module gyf_smul
   import gyf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  gyf_mul_req_type           mul_req,
   output logic                      done,
   output logic signed [MUL_P_W-1:0] product
);

   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic [MUL_A_W-1:0]        ma_ff, ma_in;
   logic [MUL_A_W:0]          hi_ff, hi_in;
   logic [MUL_B_W-1:0]        lo_ff, lo_in;
   logic signed [MUL_P_W-1:0] product_ff, product_in;

   logic [MUL_A_W-1:0] a_mag;
   logic [MUL_B_W-1:0] b_mag;
   logic [MUL_A_W:0]   sum;
   logic [MUL_P_W-1:0] mag;

   assign a_mag = mul_req.a[MUL_A_W-1] ? MUL_A_W'(-mul_req.a) : MUL_A_W'(mul_req.a);
   assign b_mag = mul_req.b[MUL_B_W-1] ? MUL_B_W'(-mul_req.b) : MUL_B_W'(mul_req.b);
   assign sum   = hi_ff + (lo_ff[0] ? {1'b0, ma_ff} : '0);
   assign mag   = MUL_P_W'({hi_ff, lo_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      neg_in     = neg_ff;
      ma_in      = ma_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      product_in = product_ff;
      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MUL_B_W);
         neg_in  = mul_req.a[MUL_A_W-1] ^ mul_req.b[MUL_B_W-1];
         ma_in   = a_mag;
         hi_in   = '0;
         lo_in   = b_mag;
      end else if (busy_ff && cnt_ff != '0) begin
         // add and shift right
         hi_in  = {1'b0, sum[MUL_A_W:1]};
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         product_in = neg_ff ? -mag : mag;
         done_in    = 1'b1;
         busy_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      ma_ff      <= ma_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      product_ff <= product_in;
   end

   assign done    = done_ff;
   assign product = product_ff;

endmodule

/* rtl/gyf_sdiv.sv */
// -----------------------------------------------------------------------------
// gyf_sdiv
// Unsigned restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module gyf_sdiv
   import gyf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  gyf_div_req_type    div_req,
   output logic               done,
   output logic [DIV_N_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_N_W-1:0] num_ff, num_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;

   logic [DIV_D_W:0] r_sh;
   logic [DIV_D_W:0] r_sub;
   logic             ge;

   assign r_sh  = {rem_ff, num_ff[DIV_N_W-1]};
   assign r_sub = r_sh - {1'b0, den_ff};
   assign ge    = r_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_N_W);
         num_in  = div_req.num;
         rem_in  = '0;
         den_in  = div_req.den;
      end else if (busy_ff && cnt_ff != '0) begin
         rem_in = ge ? r_sub[DIV_D_W-1:0] : r_sh[DIV_D_W-1:0];
         num_in = {num_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end else if (busy_ff) begin
         done_in = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

/* rtl/gyro_yaw_fusion_estimator.sv */
// -----------------------------------------------------------------------------
// gyro_yaw_fusion_estimator
// Gyro yaw integrator with rate-bias learning and module-yaw correction.
// -----------------------------------------------------------------------------
// One transaction in gives one transaction out. Commands (load calibration,
// clear integral, no-op) and uncalibrated samples go straight to the output
// state. A calibrated sample runs through one shared bit-serial multiplier
// and one shared bit-serial divider: rate scaling, optional bias update, rate
// times dt, the divide by 90, the trust divide and two correction products.
// One transaction is in work at a time; a new request is taken once the
// previous result sits in the output register, even if it has not been taken
// yet.
// -----------------------------------------------------------------------------
module gyro_yaw_fusion_estimator
   import gyf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gyf_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gyf_rsp_type           rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_MUL1 = 4'd1;  // rate times gain
   localparam logic [3:0] ST_MUL2 = 4'd2;  // bias low-pass
   localparam logic [3:0] ST_MUL3 = 4'd3;  // corrected rate times dt
   localparam logic [3:0] ST_DIV3 = 4'd4;  // divide by 90
   localparam logic [3:0] ST_CORR = 4'd5;  // error and trust setup
   localparam logic [3:0] ST_DIVT = 4'd6;  // trust divide
   localparam logic [3:0] ST_MUL4 = 4'd7;  // trust times gain
   localparam logic [3:0] ST_MUL5 = 4'd8;  // times error
   localparam logic [3:0] ST_OUT  = 4'd9;  // load output register

   // Configuration
   logic signed [15:0] cfg_rate_gain_ff;
   logic [22:0]        cfg_still_limit_ff;
   logic [7:0]         cfg_still_need_ff;
   logic [15:0]        cfg_bias_coef_ff;
   logic [15:0]        cfg_trust_angle_ff;
   logic [15:0]        cfg_max_err_ff;
   logic [15:0]        cfg_gain_moving_ff;
   logic [15:0]        cfg_gain_static_ff;

   // Control and architectural state
   logic [3:0]         state_ff, state_in;
   logic [47:0]        accum_ff, accum_in;
   logic signed [23:0] rb_ff, rb_in;
   logic [31:0]        last_ff, last_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic               cal_ff, cal_in;
   logic signed [15:0] off_ff, off_in;
   logic               tv_ff, tv_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-transaction working registers
   gyf_req_type        req_ff, req_in;
   logic signed [23:0] meas_ff, meas_in;
   logic [7:0]         dt_ff, dt_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] yf_ff, yf_in;
   logic signed [15:0] err_ff, err_in;
   logic [31:0]        corr_ff, corr_in;
   gyf_rsp_type        rsp_ff, rsp_in;

   // Arithmetic units
   gyf_mul_req_type           mul_req;
   logic                      mul_done;
   logic signed [MUL_P_W-1:0] mul_product;
   gyf_div_req_type           div_req;
   logic                      div_done;
   logic [DIV_N_W-1:0]        div_quotient;

   gyf_smul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   gyf_sdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Datapath helpers
   logic signed [23:0] meas_new;
   logic [23:0]        meas_abs;
   logic               rate_low;
   logic [31:0]        dt_raw;
   logic [7:0]         dt_cap;
   logic [7:0]         cnt_next;
   logic               still_next;
   logic               still_now;
   logic signed [24:0] diff_new;
   logic signed [23:0] rb_upd;
   logic signed [24:0] diff_upd;
   logic signed [24:0] diff_p3;
   logic [MUL_P_W-1:0] p_abs;
   logic [DIV_N_W-1:0] dt_num;
   logic [47:0]        accum_step;
   logic signed [15:0] wrap_int;
   logic signed [16:0] yf_ext;
   logic [16:0]        afused;
   logic [15:0]        trust_span;
   logic [16:0]        trust;
   logic [15:0]        err_abs;
   logic [15:0]        kp;
   logic [31:0]        out_sum;

   assign meas_new   = sat_bias(mul_product >>> 6);
   assign meas_abs   = meas_new[23] ? 24'(-meas_new) : 24'(meas_new);
   assign rate_low   = meas_abs < {1'b0, cfg_still_limit_ff};
   assign dt_raw     = req_ff.tick_ms - last_ff;
   assign dt_cap     = (dt_raw > 32'(DT_CAP_MS)) ? DT_CAP_MS : dt_raw[7:0];
   assign cnt_next   = rate_low ? ((cnt_ff == COUNT_MAX) ? COUNT_MAX : cnt_ff + 8'd1) : 8'd0;
   assign still_next = cnt_next >= cfg_still_need_ff;
   assign still_now  = cnt_ff >= cfg_still_need_ff;
   assign diff_new   = {meas_new[23], meas_new} - {rb_ff[23], rb_ff};
   assign rb_upd     = sat_bias($signed({{(MUL_P_W-24){rb_ff[23]}}, rb_ff})
                                + (mul_product >>> 16));
   assign diff_upd   = {meas_ff[23], meas_ff} - {rb_upd[23], rb_upd};
   assign diff_p3    = (state_ff == ST_MUL1) ? diff_new : diff_upd;
   assign p_abs      = mul_product[MUL_P_W-1] ? MUL_P_W'(-mul_product)
                                              : MUL_P_W'(mul_product);
   // floor of a negative quotient: round the magnitude up
   assign dt_num     = {p_abs[33:0], 8'd0}
                       + (mul_product[MUL_P_W-1] ? DT_ROUND_UP : '0);
   assign accum_step = neg_ff ? -48'(div_quotient) : 48'(div_quotient);
   assign wrap_int   = accum_ff[31:16];
   assign yf_ext     = {yf_ff[15], yf_ff};
   assign afused     = yf_ff[15] ? 17'(-yf_ext) : 17'(yf_ext);
   assign trust_span = 16'({1'b0, cfg_trust_angle_ff} - afused);
   assign trust      = div_quotient[16:0];
   assign err_abs    = err_ff[15] ? 16'(-err_ff) : 16'(err_ff);
   assign kp         = still_now ? cfg_gain_static_ff : cfg_gain_moving_ff;
   assign out_sum    = accum_ff[31:0] + corr_ff;

   always_comb begin
      state_in     = state_ff;
      accum_in     = accum_ff;
      rb_in        = rb_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      cal_in       = cal_ff;
      off_in       = off_ff;
      tv_in        = tv_ff;
      req_in       = req_ff;
      meas_in      = meas_ff;
      dt_in        = dt_ff;
      neg_in       = neg_ff;
      yf_in        = yf_ff;
      err_in       = err_ff;
      corr_in      = corr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mul_req      = '0;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = ST_OUT;
               case (req_payload.op)
                  OP_LOAD_CAL: begin
                     off_in   = req_payload.yaw_offset_value;
                     rb_in    = req_payload.bias_value;
                     cal_in   = 1'b1;
                     accum_in = '0;
                     cnt_in   = '0;
                     last_in  = req_payload.tick_ms;
                     tv_in    = 1'b1;
                  end
                  OP_CLEAR_INT: begin
                     accum_in = '0;
                     cnt_in   = '0;
                     last_in  = req_payload.tick_ms;
                     tv_in    = 1'b1;
                  end
                  OP_SAMPLE: begin
                     if (cal_ff) begin
                        yf_in       = req_payload.yaw_raw - off_ff;
                        mul_req.start = 1'b1;
                        mul_req.a   = {{(MUL_A_W-16){cfg_rate_gain_ff[15]}}, cfg_rate_gain_ff};
                        mul_req.b   = {{(MUL_B_W-16){req_payload.rate_raw[15]}},
                                       req_payload.rate_raw};
                        state_in    = ST_MUL1;
                     end else begin
                        yf_in = req_payload.yaw_raw;
                     end
                  end
                  default: begin
                     // no-op: report state only
                  end
               endcase
            end
         end

         ST_MUL1: begin
            if (mul_done) begin
               meas_in = meas_new;
               last_in = req_ff.tick_ms;
               tv_in   = 1'b1;
               if (!tv_ff || dt_raw == '0) begin
                  // first tick only latches; zero dt skips integration
                  state_in = ST_CORR;
               end else begin
                  dt_in  = dt_cap;
                  cnt_in = cnt_next;
                  mul_req.start = 1'b1;
                  if (still_next) begin
                     mul_req.a = {{(MUL_A_W-16){1'b0}}, cfg_bias_coef_ff};
                     mul_req.b = {diff_new[24], diff_new};
                     state_in  = ST_MUL2;
                  end else begin
                     mul_req.a = {{(MUL_A_W-25){diff_p3[24]}}, diff_p3};
                     mul_req.b = {{(MUL_B_W-8){1'b0}}, dt_cap};
                     state_in  = ST_MUL3;
                  end
               end
            end
         end

         ST_MUL2: begin
            if (mul_done) begin
               rb_in         = rb_upd;
               mul_req.start = 1'b1;
               mul_req.a     = {{(MUL_A_W-25){diff_p3[24]}}, diff_p3};
               mul_req.b     = {{(MUL_B_W-8){1'b0}}, dt_ff};
               state_in      = ST_MUL3;
            end
         end

         ST_MUL3: begin
            if (mul_done) begin
               neg_in        = mul_product[MUL_P_W-1];
               div_req.start = 1'b1;
               div_req.num   = dt_num;
               div_req.den   = DT_DIVISOR;
               state_in      = ST_DIV3;
            end
         end

         ST_DIV3: begin
            if (div_done) begin
               accum_in = accum_ff + accum_step;
               state_in = ST_CORR;
            end
         end

         ST_CORR: begin
            err_in  = yf_ff - wrap_int;
            corr_in = '0;
            if (afused < {1'b0, cfg_trust_angle_ff}) begin
               div_req.start = 1'b1;
               div_req.num   = DIV_N_W'({trust_span, 16'd0});
               div_req.den   = cfg_trust_angle_ff;
               state_in      = ST_DIVT;
            end else begin
               state_in = ST_OUT;
            end
         end

         ST_DIVT: begin
            if (div_done) begin
               if (trust != '0 && err_abs <= cfg_max_err_ff) begin
                  mul_req.start = 1'b1;
                  mul_req.a     = {{(MUL_A_W-17){1'b0}}, trust};
                  mul_req.b     = {{(MUL_B_W-16){1'b0}}, kp};
                  state_in      = ST_MUL4;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_MUL4: begin
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_product[MUL_A_W-1:0];
               mul_req.b     = {{(MUL_B_W-16){err_ff[15]}}, err_ff};
               state_in      = ST_MUL5;
            end
         end

         ST_MUL5: begin
            if (mul_done) begin
               corr_in  = mul_product[47:16];
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.yaw_integral  = accum_ff[47:16];
               rsp_in.bias_out      = rb_ff;
               rsp_in.is_still      = still_now;
               rsp_in.is_calibrated = cal_ff;
               if (req_ff.op == OP_SAMPLE) begin
                  rsp_in.yaw_out   = cal_ff ? out_sum[31:16] : yf_ff;
                  rsp_in.yaw_fused = yf_ff;
                  rsp_in.yaw_diff  = yf_ff - wrap_int;
               end else begin
                  rsp_in.yaw_out   = '0;
                  rsp_in.yaw_fused = '0;
                  rsp_in.yaw_diff  = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         accum_ff     <= '0;
         rb_ff        <= '0;
         last_ff      <= '0;
         cnt_ff       <= '0;
         cal_ff       <= 1'b0;
         off_ff       <= '0;
         tv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accum_ff     <= accum_in;
         rb_ff        <= rb_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         cal_ff       <= cal_in;
         off_ff       <= off_in;
         tv_ff        <= tv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      meas_ff <= meas_in;
      dt_ff   <= dt_in;
      neg_ff  <= neg_in;
      yf_ff   <= yf_in;
      err_ff  <= err_in;
      corr_ff <= corr_in;
      rsp_ff  <= rsp_in;
   end

   // Configuration writes land directly; user keeps block idle, unenforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rate_gain_ff   <= 16'sd16384;
         cfg_still_limit_ff <= 23'd2048;
         cfg_still_need_ff  <= 8'd10;
         cfg_bias_coef_ff   <= 16'd66;
         cfg_trust_angle_ff <= 16'd5461;
         cfg_max_err_ff     <= 16'd1820;
         cfg_gain_moving_ff <= 16'd655;
         cfg_gain_static_ff <= 16'd3277;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE_GAIN:   cfg_rate_gain_ff   <= csr_wdata[15:0];
            CSR_STILL_LIMIT: cfg_still_limit_ff <= csr_wdata;
            CSR_STILL_NEED:  cfg_still_need_ff  <= csr_wdata[7:0];
            CSR_BIAS_COEF:   cfg_bias_coef_ff   <= csr_wdata[15:0];
            CSR_TRUST_ANGLE: cfg_trust_angle_ff <= csr_wdata[15:0];
            CSR_MAX_ERR:     cfg_max_err_ff     <= csr_wdata[15:0];
            CSR_GAIN_MOVING: cfg_gain_moving_ff <= csr_wdata[15:0];
            CSR_GAIN_STATIC: cfg_gain_static_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* rtl/gyf_checker.sv */
// -----------------------------------------------------------------------------
// gyf_checker
// Port-level checks for the gyro yaw fusion estimator, bound to the top.
// -----------------------------------------------------------------------------
`include "gyro_yaw_fusion_estimator_defines.svh"

module gyf_checker
   import gyf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input gyf_rsp_type rsp_payload
);

   `GYF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")
   `GYF_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
   `GYF_ASSERT_SAME(a_uncal_pass, rsp_valid && !rsp_payload.is_calibrated, rsp_payload.yaw_out == rsp_payload.yaw_fused, "uncalibrated yaw not passed through")
   `GYF_ASSERT_SAME(a_uncal_int, rsp_valid && !rsp_payload.is_calibrated, rsp_payload.yaw_integral == 32'sd0, "integral moved before calibration")

endmodule

bind gyro_yaw_fusion_estimator gyf_checker u_gyf_checker (.*);
